@@ sv/bcht_pkg.sv @@
// Package for the bounded-chain hash table: sizes, codes, word types and
// the modular reduction shared by the hash datapath. No dependencies.
package bcht_pkg;

    localparam int BUCKETS     = 127;
    localparam int CHAIN_DEPTH = 3;
    localparam int KEY_BYTES   = 20;

    localparam int SLOTS   = BUCKETS * CHAIN_DEPTH;
    localparam int B_W     = $clog2(BUCKETS);
    localparam int FILL_W  = $clog2(CHAIN_DEPTH + 1);
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int NCNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W   = KEY_BYTES * 8;
    localparam int CNT_W   = $clog2(KEY_BYTES + 1);
    localparam int BIDX_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int BASE_W  = 7;
    localparam int LOST_W  = 9;
    localparam int PROD_W  = 8 + B_W + 1;

    localparam int RECIP_SH = PROD_W + B_W + 2;
    localparam logic [RECIP_SH-1:0] RECIP_V = RECIP_SH'((64'd1 << RECIP_SH) / BUCKETS);

    localparam logic [BASE_W-1:0] INITIAL_BASE_RST = BASE_W'(31);
    localparam logic [BASE_W-1:0] SECOND_BASE_RST  = BASE_W'(53);
    localparam logic [B_W-1:0]    POWER_ONE        = B_W'(1 % BUCKETS);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_FULL       = 3'd1,
        ST_FOUND      = 3'd2,
        ST_ABSENT     = 3'd3,
        ST_DELETED    = 3'd4,
        ST_DEL_ABSENT = 3'd5
    } status_t;

    typedef enum logic {
        CFG_INITIAL_BASE = 1'b0,
        CFG_SECOND_BASE  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] key_byte;
        logic       key_last;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [6:0]        bucket;
        logic [1:0]        slot;
        logic              rebalanced;
        logic              rebalance_blocked;
        logic [LOST_W-1:0] lost_keys;
    } result_t;

    function automatic logic [B_W-1:0] mod_b(input logic [PROD_W-1:0] x);
        logic [PROD_W+RECIP_SH-1:0] t;
        logic [PROD_W-1:0]          q;
        logic [PROD_W-1:0]          r;
        t = {{RECIP_SH{1'b0}}, x} * {{PROD_W{1'b0}}, RECIP_V};
        q = PROD_W'(t >> RECIP_SH);
        r = x - PROD_W'(q * PROD_W'(BUCKETS));
        if (r >= PROD_W'(BUCKETS))
        begin
            r = r - PROD_W'(BUCKETS);
        end
        return B_W'(r);
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_addr(input logic [B_W-1:0] b,
                                                     input logic [FILL_W-1:0] s);
        return SLOT_AW'(SLOT_AW'(b) * SLOT_AW'(CHAIN_DEPTH) + SLOT_AW'(s));
    endfunction

endpackage

@@ sv/bounded_chain_hash_table.sv @@
// Bounded-chain polynomial hash table: key hashing, bucket lookup, delete
// with move-down, and the one-time rehash. Depends on bcht_pkg.
//
//  channel  | handshake               | word
//  ---------+-------------------------+-----------------------------------
//  item     | start & !busy           | item_t: req_type, key_byte, key_last
//  result   | done (one cycle)        | result_t: status .. lost_keys
//  config   | cfg_valid & cfg_ready   | cfg_index, cfg_data (base value)
//
// Each key byte takes one multiply, then one modular reduction. After the
// last byte, the bucket's fill count is read; insert then writes the key,
// while find/delete read and compare the bucket's slots one at a time,
// bounded by single-port reads of the key memory. The one-time rehash walks
// the key memory, then rehashes each key, one multiply and reduction per byte.
// Reset is asynchronous; fill valid bits clear at once, no clearing pass.
// Results cannot be stalled; config is ready only while idle.
module bounded_chain_hash_table
    import bcht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_idx_t          cfg_index,
    input  logic [BASE_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_HASH, S_LOOKUP, S_FILL, S_KRD, S_KCMP, S_LRD, S_LMOVE,
        S_RFRD, S_RFILL, S_RKRD, S_RKCPY, S_RSWITCH, S_RBRD, S_RBLOAD,
        S_RHMUL, S_RHMOD, S_RFRD2, S_RPLACE
    } state_t;

    state_t              state_reg;
    logic                done_reg;
    result_t             result_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    rkey_reg;
    logic [B_W-1:0]      hash_reg;
    logic [B_W-1:0]      power_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    j_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   pprod_reg;
    logic                upd_reg;
    logic                last_reg;
    req_t                req_reg;
    logic [B_W-1:0]      bucket_reg;
    logic [FILL_W-1:0]   slot_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   rs_reg;
    logic [B_W-1:0]      rb_reg;
    logic [NCNT_W-1:0]   n_reg;
    logic [NCNT_W-1:0]   i_reg;
    logic [LOST_W-1:0]   lost_reg;
    logic [BASE_W-1:0]   cur_base_reg;
    logic [BASE_W-1:0]   sec_base_reg;
    logic                rdone_reg;

    logic [KEY_W-1:0]    key_mem [SLOTS];
    logic [KEY_W-1:0]    buf_mem [SLOTS];
    logic [FILL_W-1:0]   fill_mem [BUCKETS];
    logic [BUCKETS-1:0]  fill_vld_reg;
    logic [KEY_W-1:0]    key_rd_reg;
    logic [KEY_W-1:0]    buf_rd_reg;
    logic [FILL_W-1:0]   fill_rd_reg;
    logic                fill_vld_rd_reg;

    logic                key_we;
    logic [SLOT_AW-1:0]  key_waddr;
    logic [KEY_W-1:0]    key_wdata;
    logic [SLOT_AW-1:0]  key_raddr;
    logic                buf_we;
    logic                fill_we;
    logic [B_W-1:0]      fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;
    logic [B_W-1:0]      fill_raddr;
    logic                fill_clr;

    logic                accept;
    logic [FILL_W-1:0]   fill_now;
    logic                has_room;
    logic                key_match;
    logic [FILL_W-1:0]   last_slot;
    logic [7:0]          mul_byte;
    logic [PROD_W-1:0]   prod_next;
    logic [PROD_W-1:0]   pprod_next;
    logic [B_W-1:0]      hash_mod;
    logic [B_W-1:0]      pow_mod;
    logic [B_W-1:0]      hash_new;
    logic [LOST_W-1:0]   lost_inc;

    function automatic result_t pack_res(input status_t st, input logic [6:0] b,
                                         input logic [1:0] sl, input logic rb,
                                         input logic bl, input logic [LOST_W-1:0] lo);
        result_t r;
        r.status            = st;
        r.bucket            = b;
        r.slot              = sl;
        r.rebalanced        = rb;
        r.rebalance_blocked = bl;
        r.lost_keys         = lo;
        return r;
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = !busy;
    assign accept    = start && !busy;

    assign fill_now  = fill_vld_rd_reg ? fill_rd_reg : '0;
    assign has_room  = (fill_now < FILL_W'(CHAIN_DEPTH));
    assign key_match = (key_rd_reg == key_reg);
    assign last_slot = fill_reg - FILL_W'(1);
    assign lost_inc  = has_room ? lost_reg : lost_reg + LOST_W'(1);

    assign mul_byte   = (state_reg == S_RHMUL) ? rkey_reg[j_reg[BIDX_W-1:0]*8 +: 8]
                                               : item.key_byte;
    assign prod_next  = PROD_W'(mul_byte) * PROD_W'(power_reg) + PROD_W'(hash_reg);
    assign pprod_next = PROD_W'(power_reg) * PROD_W'(cur_base_reg);
    assign hash_mod   = mod_b(prod_reg);
    assign pow_mod    = mod_b(pprod_reg);
    assign hash_new   = upd_reg ? hash_mod : hash_reg;

    always_comb
    begin
        key_we     = 1'b0;
        key_waddr  = '0;
        key_wdata  = key_reg;
        key_raddr  = '0;
        buf_we     = 1'b0;
        fill_we    = 1'b0;
        fill_waddr = bucket_reg;
        fill_wdata = '0;
        fill_raddr = bucket_reg;
        fill_clr   = 1'b0;
        unique case (state_reg)
            S_FILL:
            begin
                if (req_reg == REQ_INSERT && has_room)
                begin
                    key_we     = 1'b1;
                    key_waddr  = slot_addr(bucket_reg, fill_now);
                    fill_we    = 1'b1;
                    fill_wdata = fill_now + FILL_W'(1);
                end
            end
            S_KRD:     key_raddr = slot_addr(bucket_reg, slot_reg);
            S_KCMP:
            begin
                if (key_match && req_reg == REQ_DELETE && slot_reg == last_slot)
                begin
                    fill_we    = 1'b1;
                    fill_wdata = last_slot;
                end
            end
            S_LRD:     key_raddr = slot_addr(bucket_reg, last_slot);
            S_LMOVE:
            begin
                key_we     = 1'b1;
                key_waddr  = slot_addr(bucket_reg, slot_reg);
                key_wdata  = key_rd_reg;
                fill_we    = 1'b1;
                fill_wdata = last_slot;
            end
            S_RFRD:    fill_raddr = rb_reg;
            S_RKRD:    key_raddr = slot_addr(rb_reg, rs_reg);
            S_RKCPY:   buf_we = 1'b1;
            S_RSWITCH: fill_clr = 1'b1;
            S_RFRD2:   fill_raddr = hash_reg;
            S_RPLACE:
            begin
                if (has_room)
                begin
                    key_we     = 1'b1;
                    key_waddr  = slot_addr(hash_reg, fill_now);
                    key_wdata  = rkey_reg;
                    fill_we    = 1'b1;
                    fill_waddr = hash_reg;
                    fill_wdata = fill_now + FILL_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[n_reg[SLOT_AW-1:0]] <= key_rd_reg;
        end
        buf_rd_reg <= buf_mem[i_reg[SLOT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_rd_reg     <= fill_mem[fill_raddr];
        fill_vld_rd_reg <= fill_vld_reg[fill_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_vld_reg <= '0;
        end
        else if (fill_clr)
        begin
            fill_vld_reg <= '0;
        end
        else if (fill_we)
        begin
            fill_vld_reg[fill_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            result_reg   <= '0;
            key_reg      <= '0;
            rkey_reg     <= '0;
            hash_reg     <= '0;
            power_reg    <= POWER_ONE;
            count_reg    <= '0;
            j_reg        <= '0;
            prod_reg     <= '0;
            pprod_reg    <= '0;
            upd_reg      <= 1'b0;
            last_reg     <= 1'b0;
            req_reg      <= REQ_INSERT;
            bucket_reg   <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            rs_reg       <= '0;
            rb_reg       <= '0;
            n_reg        <= '0;
            i_reg        <= '0;
            lost_reg     <= '0;
            cur_base_reg <= INITIAL_BASE_RST;
            sec_base_reg <= SECOND_BASE_RST;
            rdone_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready && !rdone_reg)
            begin
                unique case (cfg_index)
                    CFG_INITIAL_BASE: cur_base_reg <= cfg_data;
                    CFG_SECOND_BASE:  sec_base_reg <= cfg_data;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= req_t'(item.req_type);
                        last_reg  <= item.key_last;
                        prod_reg  <= prod_next;
                        pprod_reg <= pprod_next;
                        upd_reg   <= (count_reg < CNT_W'(KEY_BYTES));
                        if (count_reg == '0)
                        begin
                            key_reg <= KEY_W'(item.key_byte);
                        end
                        else if (count_reg < CNT_W'(KEY_BYTES))
                        begin
                            key_reg[count_reg[BIDX_W-1:0]*8 +: 8] <= item.key_byte;
                        end
                        if (count_reg < CNT_W'(KEY_BYTES))
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (!last_reg)
                    begin
                        hash_reg  <= hash_new;
                        if (upd_reg)
                        begin
                            power_reg <= pow_mod;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        hash_reg   <= '0;
                        power_reg  <= POWER_ONE;
                        count_reg  <= '0;
                        bucket_reg <= hash_new;
                        state_reg  <= (req_reg == REQ_NONE) ? S_IDLE : S_LOOKUP;
                    end
                end
                S_LOOKUP: state_reg <= S_FILL;
                S_FILL:
                begin
                    fill_reg <= fill_now;
                    slot_reg <= '0;
                    if (req_reg == REQ_INSERT)
                    begin
                        if (!has_room)
                        begin
                            result_reg <= pack_res(ST_FULL, bucket_reg, 2'd0, 1'b0, 1'b0, '0);
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else if (fill_now + FILL_W'(1) == FILL_W'(CHAIN_DEPTH) && !rdone_reg)
                        begin
                            slot_reg  <= fill_now;
                            rb_reg    <= '0;
                            n_reg     <= '0;
                            state_reg <= S_RFRD;
                        end
                        else
                        begin
                            result_reg <= pack_res(ST_INSERTED, bucket_reg, 2'(fill_now), 1'b0,
                                fill_now + FILL_W'(1) == FILL_W'(CHAIN_DEPTH), '0);
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else if (fill_now == '0)
                    begin
                        result_reg <= pack_res((req_reg == REQ_FIND) ? ST_ABSENT : ST_DEL_ABSENT,
                                               bucket_reg, 2'd0, 1'b0, 1'b0, '0);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_KRD;
                    end
                end
                S_KRD: state_reg <= S_KCMP;
                S_KCMP:
                begin
                    if (key_match)
                    begin
                        if (req_reg == REQ_FIND)
                        begin
                            result_reg <= pack_res(ST_FOUND, bucket_reg, 2'(slot_reg),
                                                   1'b0, 1'b0, '0);
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else if (slot_reg == last_slot)
                        begin
                            result_reg <= pack_res(ST_DELETED, bucket_reg, 2'(slot_reg),
                                                   1'b0, 1'b0, '0);
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_LRD;
                        end
                    end
                    else if (slot_reg == last_slot)
                    begin
                        result_reg <= pack_res((req_reg == REQ_FIND) ? ST_ABSENT : ST_DEL_ABSENT,
                                               bucket_reg, 2'd0, 1'b0, 1'b0, '0);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + FILL_W'(1);
                        state_reg <= S_KRD;
                    end
                end
                S_LRD: state_reg <= S_LMOVE;
                S_LMOVE:
                begin
                    result_reg <= pack_res(ST_DELETED, bucket_reg, 2'(slot_reg), 1'b0, 1'b0, '0);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_RFRD: state_reg <= S_RFILL;
                S_RFILL:
                begin
                    fill_reg <= fill_now;
                    rs_reg   <= '0;
                    if (fill_now != '0)
                    begin
                        state_reg <= S_RKRD;
                    end
                    else if (rb_reg == B_W'(BUCKETS - 1))
                    begin
                        state_reg <= S_RSWITCH;
                    end
                    else
                    begin
                        rb_reg    <= rb_reg + B_W'(1);
                        state_reg <= S_RFRD;
                    end
                end
                S_RKRD: state_reg <= S_RKCPY;
                S_RKCPY:
                begin
                    n_reg <= n_reg + NCNT_W'(1);
                    if (rs_reg != last_slot)
                    begin
                        rs_reg    <= rs_reg + FILL_W'(1);
                        state_reg <= S_RKRD;
                    end
                    else if (rb_reg == B_W'(BUCKETS - 1))
                    begin
                        state_reg <= S_RSWITCH;
                    end
                    else
                    begin
                        rb_reg    <= rb_reg + B_W'(1);
                        state_reg <= S_RFRD;
                    end
                end
                S_RSWITCH:
                begin
                    cur_base_reg <= sec_base_reg;
                    rdone_reg    <= 1'b1;
                    i_reg        <= '0;
                    lost_reg     <= '0;
                    if (n_reg == '0)
                    begin
                        result_reg <= pack_res(ST_INSERTED, bucket_reg, 2'(slot_reg),
                                               1'b1, 1'b0, '0);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RBRD;
                    end
                end
                S_RBRD: state_reg <= S_RBLOAD;
                S_RBLOAD:
                begin
                    rkey_reg  <= buf_rd_reg;
                    hash_reg  <= '0;
                    power_reg <= POWER_ONE;
                    j_reg     <= '0;
                    state_reg <= S_RHMUL;
                end
                S_RHMUL:
                begin
                    prod_reg  <= prod_next;
                    pprod_reg <= pprod_next;
                    state_reg <= S_RHMOD;
                end
                S_RHMOD:
                begin
                    hash_reg  <= hash_mod;
                    power_reg <= pow_mod;
                    if (j_reg == CNT_W'(KEY_BYTES - 1))
                    begin
                        state_reg <= S_RFRD2;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= S_RHMUL;
                    end
                end
                S_RFRD2: state_reg <= S_RPLACE;
                S_RPLACE:
                begin
                    lost_reg <= lost_inc;
                    if (i_reg + NCNT_W'(1) == n_reg)
                    begin
                        hash_reg   <= '0;
                        power_reg  <= POWER_ONE;
                        result_reg <= pack_res(ST_INSERTED, bucket_reg, 2'(slot_reg),
                                               1'b1, 1'b0, lost_inc);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NCNT_W'(1);
                        state_reg <= S_RBRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/bcht_checker.sv @@
// Port-level checks for the bounded-chain hash table, bound to the top level.
// Depends on bcht_pkg.
module bcht_checker
    import bcht_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= 3'd5)
        else $error("status code out of range");

    a_rebalance_insert: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.rebalanced || result.rebalance_blocked)
            |-> result.status == ST_INSERTED && result.slot == 2'(CHAIN_DEPTH - 1))
        else $error("rebalance flag on a result that did not fill a bucket");

endmodule

bind bounded_chain_hash_table bcht_checker u_bcht_checker (.*);
